### rtl/psbin_pkg.sv
package psbin_pkg;

    localparam int DEF_SPEED_BIN_COUNT = 1024;
    localparam int DEF_TIME_EDGES      = 256;
    localparam int FIFO_DEPTH          = 4;
    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PART = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [9:0]         index;
        logic signed [31:0] edge_time;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] vel_z;
        logic [31:0]        particle_mass;
        logic signed [31:0] creation_time;
        logic [31:0]        metallicity;
    } item_t;

    typedef struct packed {
        logic [9:0]  bin_index;
        logic [31:0] speed_count;
        logic [47:0] mass_sum;
        logic [31:0] particle_count;
        logic [23:0] min_speed;
        logic [23:0] max_speed;
        logic [31:0] min_mass;
        logic [31:0] max_mass;
        logic [31:0] min_metal;
        logic [31:0] max_metal;
    } result_t;

endpackage

### rtl/psbin_ram.sv
module psbin_ram #(
    parameter int W = 32,
    parameter int D = 256,
    localparam int AW = $clog2(D)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/psbin_front.sv
module psbin_front
    import psbin_pkg::*;
#(
    parameter int TIME_EDGES = DEF_TIME_EDGES
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  item_t  in_item,
    input  logic   clearing,
    output logic   head_valid,
    output item_t  head,
    input  logic   pop
);

    localparam int PW = $clog2(FIFO_DEPTH);

    item_t           fifo_reg [FIFO_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            keep, push;

    // Unknown request types and loads past the edge table do nothing, so drop them here.
    always_comb
    begin
        keep = (in_item.req_type == REQ_PART) || (in_item.req_type == REQ_READ) ||
               ((in_item.req_type == REQ_LOAD) && (32'(in_item.index) < 32'(TIME_EDGES)));
    end

    assign in_ready   = !clearing && (cnt_reg != (PW+1)'(FIFO_DEPTH));
    assign push       = in_valid && in_ready && keep;
    assign head_valid = cnt_reg != '0;
    assign head       = fifo_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= in_item;
        end
    end

endmodule

### rtl/psbin_back.sv
module psbin_back
    import psbin_pkg::*;
#(
    parameter int SPEED_BIN_COUNT = DEF_SPEED_BIN_COUNT,
    parameter int TIME_EDGES      = DEF_TIME_EDGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] speed_scale,
    input  logic        head_valid,
    input  item_t       head,
    output logic        pop,
    output logic        clearing,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_data
);

    localparam int EAW     = $clog2(TIME_EDGES);
    localparam int MD      = TIME_EDGES - 1;
    localparam int MAW     = $clog2(MD);
    localparam int HAW     = $clog2(SPEED_BIN_COUNT);
    localparam int TW      = EAW + 1;
    localparam int CLR_LEN = (SPEED_BIN_COUNT > TIME_EDGES) ? SPEED_BIN_COUNT : TIME_EDGES;
    localparam int CW      = $clog2(CLR_LEN);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_PART = 2'd2;
    localparam logic [1:0] ST_RD   = 2'd3;

    localparam logic [2:0] SP_IDLE = 3'd0;
    localparam logic [2:0] SP_SQ   = 3'd1;
    localparam logic [2:0] SP_SUM  = 3'd2;
    localparam logic [2:0] SP_ROOT = 3'd3;
    localparam logic [2:0] SP_MUL  = 3'd4;
    localparam logic [2:0] SP_BIN  = 3'd5;
    localparam logic [2:0] SP_HRD  = 3'd6;
    localparam logic [2:0] SP_DONE = 3'd7;

    logic [1:0]   st_reg;
    logic [2:0]   sp_reg;
    logic         hwr_reg;
    logic [CW-1:0] clr_reg;
    logic         scan_act_reg, p_valid_reg;
    logic [TW-1:0] scan_t_reg;
    logic [MAW-1:0] p_i_reg;
    logic signed [31:0] prev_edge_reg;

    logic signed [23:0] vx_reg, vy_reg, vz_reg;
    logic [31:0]  w_mass_reg, w_metal_reg;
    logic signed [31:0] w_ct_reg;
    logic [47:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [48:0]  n_reg, root_reg;
    logic [4:0]   k_reg;
    logic [55:0]  prod_reg;
    logic [HAW-1:0] bin_reg;
    logic [23:0]  speed_reg;

    logic [9:0]   rd_idx_reg;
    logic         rd_hv_reg, rd_mv_reg;

    logic [31:0]  seen_reg;
    logic [23:0]  spd_lo_reg, spd_hi_reg;
    logic [31:0]  mass_lo_reg, mass_hi_reg, metal_lo_reg, metal_hi_reg;

    logic         m_valid_reg;
    result_t      m_data_reg;

    logic         e_we, h_we, m_we;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic [31:0]  e_wdata, e_rdata;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [31:0]  h_wdata, h_rdata;
    logic [MAW-1:0] m_waddr, m_raddr;
    logic [47:0]  m_wdata, m_rdata;

    logic         out_free, go_load, go_part, go_read, part_done, match;
    logic [48:0]  bitv, trial, msum;
    logic [39:0]  bin_raw;
    logic         first;
    logic [23:0]  s_lo, s_hi;
    logic [31:0]  ma_lo, ma_hi, me_lo, me_hi;

    assign clearing  = st_reg == ST_CLR;
    assign out_free  = !m_valid_reg || m_ready;
    assign go_load   = head_valid && (head.req_type == REQ_LOAD);
    assign go_part   = head_valid && (head.req_type == REQ_PART);
    assign go_read   = head_valid && (head.req_type == REQ_READ) && out_free;
    assign pop       = (st_reg == ST_IDLE) && (go_load || go_part || go_read);
    assign part_done = (st_reg == ST_PART) && !scan_act_reg && !p_valid_reg &&
                       (sp_reg == SP_DONE);

    // Interval p_i lies between the edge loaded last cycle and the one arriving now.
    assign match = (prev_edge_reg < w_ct_reg) && (w_ct_reg <= $signed(e_rdata));
    assign msum  = {1'b0, m_rdata} + 49'(w_mass_reg);

    assign bitv    = 49'(1) << {k_reg, 1'b0};
    assign trial   = root_reg + bitv;
    assign bin_raw = prod_reg[55:16];

    always_comb
    begin
        e_we    = clearing ? (32'(clr_reg) < 32'(TIME_EDGES)) : ((st_reg == ST_IDLE) && go_load);
        e_waddr = clearing ? EAW'(clr_reg) : EAW'(head.index);
        e_wdata = clearing ? '1 : head.edge_time;
        e_raddr = EAW'(scan_t_reg);

        h_we    = clearing ? (32'(clr_reg) < 32'(SPEED_BIN_COUNT)) : hwr_reg;
        h_waddr = clearing ? HAW'(clr_reg) : bin_reg;
        h_wdata = clearing ? '0 : ((h_rdata == '1) ? h_rdata : h_rdata + 32'd1);
        h_raddr = (st_reg == ST_IDLE) ? HAW'(head.index) : bin_reg;

        m_we    = clearing ? (32'(clr_reg) < 32'(MD)) : (p_valid_reg && match);
        m_waddr = clearing ? MAW'(clr_reg) : p_i_reg;
        m_wdata = clearing ? '0 : (msum[48] ? '1 : msum[47:0]);
        m_raddr = (st_reg == ST_IDLE) ? MAW'(head.index) : MAW'(scan_t_reg - TW'(1));
    end

    // The first particle seeds every extreme with its own values.
    always_comb
    begin
        first = seen_reg == '0;
        s_lo  = first ? speed_reg : spd_lo_reg;
        s_hi  = first ? speed_reg : spd_hi_reg;
        ma_lo = first ? w_mass_reg : mass_lo_reg;
        ma_hi = first ? w_mass_reg : mass_hi_reg;
        me_lo = first ? w_metal_reg : metal_lo_reg;
        me_hi = first ? w_metal_reg : metal_hi_reg;
        if (speed_reg < s_lo)
        begin
            s_lo = speed_reg;
        end
        if (speed_reg > s_hi)
        begin
            s_hi = speed_reg;
        end
        if (w_mass_reg < ma_lo)
        begin
            ma_lo = w_mass_reg;
        end
        if (w_mass_reg > ma_hi)
        begin
            ma_hi = w_mass_reg;
        end
        if (w_metal_reg < me_lo)
        begin
            me_lo = w_metal_reg;
        end
        if (w_metal_reg > me_hi)
        begin
            me_hi = w_metal_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_CLR;
            sp_reg       <= SP_IDLE;
            hwr_reg      <= 1'b0;
            clr_reg      <= '0;
            scan_act_reg <= 1'b0;
            scan_t_reg   <= '0;
            p_valid_reg  <= 1'b0;
            seen_reg     <= '0;
            spd_lo_reg   <= '0;
            spd_hi_reg   <= '0;
            mass_lo_reg  <= '0;
            mass_hi_reg  <= '0;
            metal_lo_reg <= '0;
            metal_hi_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            hwr_reg <= (sp_reg == SP_HRD);
            if (m_valid_reg && m_ready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (scan_act_reg)
            begin
                scan_t_reg <= scan_t_reg + TW'(1);
                if (scan_t_reg == TW'(TIME_EDGES - 2))
                begin
                    scan_act_reg <= 1'b0;
                end
            end
            p_valid_reg <= scan_act_reg && (scan_t_reg != '0);

            case (sp_reg)
                SP_IDLE:
                begin
                    if ((st_reg == ST_IDLE) && go_part)
                    begin
                        sp_reg <= SP_SQ;
                    end
                end
                SP_SQ:   sp_reg <= SP_SUM;
                SP_SUM:  sp_reg <= SP_ROOT;
                SP_ROOT:
                begin
                    if (k_reg == '0)
                    begin
                        sp_reg <= SP_MUL;
                    end
                end
                SP_MUL:  sp_reg <= SP_BIN;
                SP_BIN:  sp_reg <= SP_HRD;
                SP_HRD:  sp_reg <= SP_DONE;
                SP_DONE:
                begin
                    if (part_done)
                    begin
                        sp_reg <= SP_IDLE;
                    end
                end
                default: sp_reg <= SP_IDLE;
            endcase

            case (st_reg)
                ST_CLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == CW'(CLR_LEN - 1))
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (go_part)
                    begin
                        st_reg       <= ST_PART;
                        scan_act_reg <= 1'b1;
                        scan_t_reg   <= '0;
                    end
                    else if (go_read)
                    begin
                        st_reg <= ST_RD;
                    end
                end
                ST_PART:
                begin
                    if (part_done)
                    begin
                        st_reg       <= ST_IDLE;
                        seen_reg     <= (seen_reg == '1) ? seen_reg : seen_reg + 32'd1;
                        spd_lo_reg   <= s_lo;
                        spd_hi_reg   <= s_hi;
                        mass_lo_reg  <= ma_lo;
                        mass_hi_reg  <= ma_hi;
                        metal_lo_reg <= me_lo;
                        metal_hi_reg <= me_hi;
                    end
                end
                ST_RD:
                begin
                    m_valid_reg <= 1'b1;
                    st_reg      <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prev_edge_reg <= $signed(e_rdata);
        p_i_reg       <= MAW'(scan_t_reg - TW'(1));
        if ((st_reg == ST_IDLE) && go_part)
        begin
            vx_reg      <= head.vel_x;
            vy_reg      <= head.vel_y;
            vz_reg      <= head.vel_z;
            w_mass_reg  <= head.particle_mass;
            w_ct_reg    <= head.creation_time;
            w_metal_reg <= head.metallicity;
        end
        if ((st_reg == ST_IDLE) && go_read)
        begin
            rd_idx_reg <= head.index;
            rd_hv_reg  <= 32'(head.index) < 32'(SPEED_BIN_COUNT);
            rd_mv_reg  <= 32'(head.index) < 32'(MD);
        end
        case (sp_reg)
            SP_SQ:
            begin
                sqx_reg <= 48'(vx_reg * vx_reg);
                sqy_reg <= 48'(vy_reg * vy_reg);
                sqz_reg <= 48'(vz_reg * vz_reg);
            end
            SP_SUM:
            begin
                n_reg    <= 49'(sqx_reg) + 49'(sqy_reg) + 49'(sqz_reg);
                root_reg <= '0;
                k_reg    <= 5'd24;
            end
            SP_ROOT:
            begin
                // One result bit per cycle, restoring method.
                if (n_reg >= trial)
                begin
                    n_reg    <= n_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                k_reg <= k_reg - 5'd1;
            end
            SP_MUL:
            begin
                speed_reg <= root_reg[23:0];
                prod_reg  <= 56'(root_reg[23:0]) * 56'(speed_scale);
            end
            SP_BIN:
            begin
                bin_reg <= (bin_raw >= 40'(SPEED_BIN_COUNT)) ? HAW'(SPEED_BIN_COUNT - 1)
                                                              : HAW'(bin_raw);
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
        if (st_reg == ST_RD)
        begin
            m_data_reg.bin_index      <= rd_idx_reg;
            m_data_reg.speed_count    <= rd_hv_reg ? h_rdata : '0;
            m_data_reg.mass_sum       <= rd_mv_reg ? m_rdata : '0;
            m_data_reg.particle_count <= seen_reg;
            m_data_reg.min_speed      <= spd_lo_reg;
            m_data_reg.max_speed      <= spd_hi_reg;
            m_data_reg.min_mass       <= mass_lo_reg;
            m_data_reg.max_mass       <= mass_hi_reg;
            m_data_reg.min_metal      <= metal_lo_reg;
            m_data_reg.max_metal      <= metal_hi_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    psbin_ram #(.W(32), .D(TIME_EDGES)) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    psbin_ram #(.W(32), .D(SPEED_BIN_COUNT)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    psbin_ram #(.W(48), .D(MD)) u_mass (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

`ifndef ASSERT_OFF
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop) else $error("item taken during clearing pass");
    a_rd_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_RD) |-> !m_valid_reg) else $error("readout overwrites pending beat");
    a_speed_order: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg != '0) |-> (spd_lo_reg <= spd_hi_reg)) else $error("speed min above max");
    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg != '0) |=> (seen_reg != '0)) else $error("particle count fell to zero");
`endif

endmodule

### rtl/particle_speed_and_time_binning.sv
// Particle speed and creation-time binning engine.
// Input beats arrive on s_axis: tuser holds the request kind (load edge,
// particle, readout) and tdata the remaining fields. Readout beats produce one
// result beat on m_axis; loads and particles produce none. cfg_* writes the
// Q16.16 speed scale and is always ready.
// A particle occupies the back end until the time edge table scan and the
// speed path are both done: the table is scanned one edge per cycle through
// its memory port, while the 25-step square root, the scale multiply and the
// histogram update run alongside.
// A load writes its edge when popped; a readout is registered through the read state.
// A four-entry queue sits between input and execution, so input beats keep
// being taken while the back end works or a result waits, until it is full.
// After reset a clearing pass over max(SPEED_BIN_COUNT, TIME_EDGES) addresses
// initialises the memories; s_axis_tready stays low during it.
// When m_axis_tready is low the result is held and the next readout waits at
// the head of the queue; the beats behind it wait too, and s_axis_tready
// falls once the queue is full.
module particle_speed_and_time_binning
    import psbin_pkg::*;
#(
    parameter int SPEED_BIN_COUNT = DEF_SPEED_BIN_COUNT,
    parameter int TIME_EDGES      = DEF_TIME_EDGES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // index, edge_time, vel_x, vel_y, vel_z, particle_mass, creation_time, metallicity
    input  logic [215:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bin_index, speed_count, mass_sum, particle_count, min_speed, max_speed,
    // min_mass, max_mass, min_metal, max_metal
    output logic [303:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    logic [31:0] speed_scale_reg;
    item_t       in_item, head;
    logic        head_valid, pop, clearing;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            speed_scale_reg <= cfg_data;
        end
    end

    always_comb
    begin
        in_item.req_type      = s_axis_tuser;
        in_item.index         = s_axis_tdata[9:0];
        in_item.edge_time     = s_axis_tdata[41:10];
        in_item.vel_x         = s_axis_tdata[65:42];
        in_item.vel_y         = s_axis_tdata[89:66];
        in_item.vel_z         = s_axis_tdata[113:90];
        in_item.particle_mass = s_axis_tdata[145:114];
        in_item.creation_time = s_axis_tdata[177:146];
        in_item.metallicity   = s_axis_tdata[209:178];
    end

    assign m_axis_tdata = {6'd0, res.max_metal, res.min_metal, res.max_mass, res.min_mass,
                           res.max_speed, res.min_speed, res.particle_count, res.mass_sum,
                           res.speed_count, res.bin_index};

    psbin_front #(.TIME_EDGES(TIME_EDGES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .clearing(clearing), .head_valid(head_valid), .head(head), .pop(pop)
    );

    psbin_back #(.SPEED_BIN_COUNT(SPEED_BIN_COUNT), .TIME_EDGES(TIME_EDGES)) u_back (
        .clk(clk), .rst_n(rst_n), .speed_scale(speed_scale_reg),
        .head_valid(head_valid), .head(head), .pop(pop), .clearing(clearing),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(res)
    );

endmodule

### verif/testbench.sv
module testbench;
    import psbin_pkg::*;

    localparam int          BINS      = DEF_SPEED_BIN_COUNT;
    localparam int          EDGES     = DEF_TIME_EDGES;
    localparam logic [1:0]  REQ_SPARE = 2'd3;
    // Enough for a full queue of particles plus the one in the back end.
    localparam int          SETTLE    = (FIFO_DEPTH + 3) * (EDGES + 4);
    localparam int          HOLD_LEN  = 3000;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [303:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    particle_speed_and_time_binning uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the binning state.
    logic [31:0]        scale_m;
    logic signed [31:0] edge_m [EDGES];
    logic [31:0]        speed_hist_m [BINS];
    logic [47:0]        time_mass_m [EDGES-1];
    logic [31:0]        seen_m;
    logic [23:0]        speed_lo_m, speed_hi_m;
    logic [31:0]        mass_lo_m, mass_hi_m, metal_lo_m, metal_hi_m;

    result_t     readouts_due [$];
    item_t       cur_item;
    bit          cur_typed;
    result_t     cur_want;
    int          beats_in;
    int          cfg_beats;
    int          errors;
    int          tx_idle;
    int          rx_idle;
    int          holds_asked;
    int          n_load, n_part, n_read, n_res;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #30000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [23:0] int_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 48;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[23:0];
    endfunction

    function automatic logic [215:0] pack_item(item_t it);
        return {6'd0, it.metallicity, it.creation_time, it.particle_mass,
                it.vel_z, it.vel_y, it.vel_x, it.edge_time, it.index};
    endfunction

    function automatic result_t unpack_result(logic [303:0] d);
        result_t r;
        r.bin_index      = d[9:0];
        r.speed_count    = d[41:10];
        r.mass_sum       = d[89:42];
        r.particle_count = d[121:90];
        r.min_speed      = d[145:122];
        r.max_speed      = d[169:146];
        r.min_mass       = d[201:170];
        r.max_mass       = d[233:202];
        r.min_metal      = d[265:234];
        r.max_metal      = d[297:266];
        return r;
    endfunction

    function automatic result_t read_bin(logic [9:0] idx);
        result_t r;
        r.bin_index      = idx;
        r.speed_count    = (idx < BINS) ? speed_hist_m[idx] : 32'd0;
        r.mass_sum       = (idx < EDGES - 1) ? time_mass_m[idx] : 48'd0;
        r.particle_count = seen_m;
        r.min_speed      = speed_lo_m;
        r.max_speed      = speed_hi_m;
        r.min_mass       = mass_lo_m;
        r.max_mass       = mass_hi_m;
        r.min_metal      = metal_lo_m;
        r.max_metal      = metal_hi_m;
        return r;
    endfunction

    task automatic bin_particle(item_t it);
        longint signed   vx, vy, vz;
        longint unsigned sq;
        longint unsigned bin;
        logic [23:0]     spd;
        logic [48:0]     acc;
        vx  = it.vel_x;
        vy  = it.vel_y;
        vz  = it.vel_z;
        sq  = vx * vx + vy * vy + vz * vz;
        spd = int_root(sq);
        bin = ({40'd0, spd} * {32'd0, scale_m}) >> 16;
        if (bin >= BINS)
            bin = BINS - 1;
        if (speed_hist_m[bin] != 32'hFFFF_FFFF)
            speed_hist_m[bin] = speed_hist_m[bin] + 1;
        if (seen_m == 0)
        begin
            speed_lo_m = spd;
            speed_hi_m = spd;
            mass_lo_m  = it.particle_mass;
            mass_hi_m  = it.particle_mass;
            metal_lo_m = it.metallicity;
            metal_hi_m = it.metallicity;
        end
        if (spd < speed_lo_m) speed_lo_m = spd;
        if (spd > speed_hi_m) speed_hi_m = spd;
        if (it.particle_mass < mass_lo_m) mass_lo_m = it.particle_mass;
        if (it.particle_mass > mass_hi_m) mass_hi_m = it.particle_mass;
        if (it.metallicity < metal_lo_m) metal_lo_m = it.metallicity;
        if (it.metallicity > metal_hi_m) metal_hi_m = it.metallicity;
        // The last interval never gains mass, so the scan stops one short.
        for (int i = 0; i < EDGES - 2; i++)
        begin
            if (edge_m[i] < it.creation_time && it.creation_time <= edge_m[i+1])
            begin
                acc = {1'b0, time_mass_m[i]} + {17'd0, it.particle_mass};
                time_mass_m[i] = acc[48] ? 48'hFFFF_FFFF_FFFF : acc[47:0];
            end
        end
        if (seen_m != 32'hFFFF_FFFF)
            seen_m = seen_m + 1;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        scale_m    = SCALE_RESET;
        seen_m     = 0;
        speed_lo_m = 0;
        speed_hi_m = 0;
        mass_lo_m  = 0;
        mass_hi_m  = 0;
        metal_lo_m = 0;
        metal_hi_m = 0;
        foreach (edge_m[i]) edge_m[i] = -1;
        foreach (speed_hist_m[i]) speed_hist_m[i] = 0;
        foreach (time_mass_m[i]) time_mass_m[i] = 0;
    end

    // Results are checked before the input beat of the same edge is absorbed.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata);
            n_res++;
            if (readouts_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %0h", $time, got);
                errors++;
            end
            else
            begin
                want = readouts_due.pop_front();
                check_field("bin_index", want.bin_index, got.bin_index);
                check_field("speed_count", want.speed_count, got.speed_count);
                check_field("mass_sum", want.mass_sum, got.mass_sum);
                check_field("particle_count", want.particle_count, got.particle_count);
                check_field("min_speed", want.min_speed, got.min_speed);
                check_field("max_speed", want.max_speed, got.max_speed);
                check_field("min_mass", want.min_mass, got.min_mass);
                check_field("max_mass", want.max_mass, got.max_mass);
                check_field("min_metal", want.min_metal, got.min_metal);
                check_field("max_metal", want.max_metal, got.max_metal);
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            case (cur_item.req_type)
                REQ_LOAD:
                begin
                    n_load++;
                    if (cur_item.index < EDGES)
                        edge_m[cur_item.index] = cur_item.edge_time;
                end
                REQ_PART:
                begin
                    n_part++;
                    bin_particle(cur_item);
                end
                REQ_READ:
                begin
                    n_read++;
                    if (cur_typed)
                        readouts_due.push_back(cur_want);
                    else
                        readouts_due.push_back(read_bin(cur_item.index));
                end
                default: ;
            endcase
            beats_in <= beats_in + 1;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            scale_m = cfg_data;
            cfg_beats <= cfg_beats + 1;
        end
    end

    // Result side: random back-pressure, with a long hold-off on request.
    initial
    begin
        int held;
        int holds_done;
        held          = 0;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                held       = HOLD_LEN;
            end
            if (held > 0)
            begin
                held--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    task automatic send_beat(item_t it, bit typed, result_t want);
        int sent;
        if (tx_idle > 0)
        begin
            while ($urandom_range(0, 99) < tx_idle)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        cur_item      = it;
        cur_typed     = typed;
        cur_want      = want;
        sent          = beats_in;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.req_type;
        do
            @(negedge clk);
        while (beats_in == sent);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (readouts_due.size() != 0)
            @(negedge clk);
        // Particles queued behind the last readout may still be in the back end.
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_scale(logic [31:0] v);
        int sent;
        drain();
        sent      = cfg_beats;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (cfg_beats == sent);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t noise_item(logic [1:0] kind);
        item_t it;
        it.req_type      = kind;
        it.index         = 10'($urandom);
        it.edge_time     = $urandom;
        it.vel_x         = 24'($urandom);
        it.vel_y         = 24'($urandom);
        it.vel_z         = 24'($urandom);
        it.particle_mass = $urandom;
        it.creation_time = $urandom;
        it.metallicity   = $urandom;
        return it;
    endfunction

    function automatic row_t load_row(int idx, int t);
        row_t r;
        r.it           = noise_item(REQ_LOAD);
        r.it.index     = 10'(idx);
        r.it.edge_time = t;
        r.typed        = 0;
        r.want         = '0;
        return r;
    endfunction

    function automatic row_t part_row(int vx, int vy, int vz, logic [31:0] m, int ct,
                                      logic [31:0] met);
        row_t r;
        r.it               = noise_item(REQ_PART);
        r.it.vel_x         = 24'(vx);
        r.it.vel_y         = 24'(vy);
        r.it.vel_z         = 24'(vz);
        r.it.particle_mass = m;
        r.it.creation_time = ct;
        r.it.metallicity   = met;
        r.typed            = 0;
        r.want             = '0;
        return r;
    endfunction

    function automatic row_t read_row(int idx);
        row_t r;
        r.it       = noise_item(REQ_READ);
        r.it.index = 10'(idx);
        r.typed    = 0;
        r.want     = '0;
        return r;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            it = noise_item(REQ_LOAD);
            it.index = 10'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 45)
                                                         : $urandom_range(0, 1023));
            if ($urandom_range(0, 9) != 0)
                it.edge_time = it.index * 1000 + $urandom_range(0, 999);
        end
        else if (pick < 60)
        begin
            it = noise_item(REQ_PART);
            if ($urandom_range(0, 9) < 7)
            begin
                it.vel_x = 24'($signed($urandom_range(0, 2000)) - 1000);
                it.vel_y = 24'($signed($urandom_range(0, 2000)) - 1000);
                it.vel_z = 24'($signed($urandom_range(0, 2000)) - 1000);
            end
            if ($urandom_range(0, 9) < 8)
                it.creation_time = $urandom_range(0, 46000);
        end
        else if (pick < 95)
        begin
            it = noise_item(REQ_READ);
            if ($urandom_range(0, 9) < 8)
                it.index = 10'($urandom_range(0, 45));
        end
        else
            it = noise_item(REQ_SPARE);
        return it;
    endfunction

    initial
    begin
        row_t        plan [$];
        row_t        r;
        logic [31:0] scales [4];
        int          tx_of [4];
        int          rx_of [4];
        beats_in      = 0;
        cfg_beats     = 0;
        errors        = 0;
        holds_asked   = 0;
        n_load        = 0;
        n_part        = 0;
        n_read        = 0;
        n_res         = 0;
        tx_idle       = 0;
        rx_idle       = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part; nothing binned yet, so the first two readouts are zero apart from the bin index.
        r = read_row(0);
        r.typed = 1;
        plan.push_back(r);
        r = read_row(1023);
        r.typed = 1;
        r.want.bin_index = 10'd1023;
        plan.push_back(r);
        plan.push_back('{noise_item(REQ_SPARE), 0, '0});
        plan.push_back(load_row(0, 32'sh8000_0000));
        plan.push_back(load_row(1, -100));
        plan.push_back(load_row(2, 100));
        plan.push_back(load_row(3, 2147483647));
        plan.push_back(load_row(255, 5));
        plan.push_back(load_row(300, 7));
        plan.push_back(part_row(0, 0, 0, 0, 32'sh8000_0000, 0));
        plan.push_back(part_row(-8388608, -8388608, -8388608, 32'hFFFF_FFFF, 0,
                                32'hFFFF_FFFF));
        plan.push_back(part_row(8388607, 8388607, 8388607, 1, 2147483647, 5));
        plan.push_back(part_row(3, 4, 0, 1000, 100, 77));
        plan.push_back(part_row(0, -5, 12, 32'h8000_0000, -100, 9));
        plan.push_back(part_row(1023, 0, 0, 3, 101, 1));
        plan.push_back(read_row(0));
        plan.push_back(read_row(1));
        plan.push_back(read_row(2));
        plan.push_back(read_row(5));
        plan.push_back(read_row(13));
        plan.push_back(read_row(254));
        plan.push_back(read_row(255));
        plan.push_back(read_row(1023));
        foreach (plan[i])
            send_beat(plan[i].it, plan[i].typed, plan[i].want);

        scales = '{32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000};
        scales[3] = $urandom_range(1, 32'h0004_0000);
        tx_of  = '{31, 88, 0, 0};
        rx_of  = '{88, 31, 0, 0};
        for (int p = 0; p < 4; p++)
        begin
            write_scale(scales[p]);
            tx_idle = tx_of[p];
            rx_idle = rx_of[p];
            if (p == 2)
                holds_asked++;
            for (int k = 0; k < 245; k++)
                send_beat(random_item(), 0, '0);
        end

        drain();
        $display("Covered %0d loads, %0d particles and %0d readouts (%0d results checked)",
                 n_load, n_part, n_read, n_res);
        $display("under four speed scales, both idling patterns and a long result stall.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
